[hdl/text_statistics_counter_macros.svh]
// Assertion macros for the text statistics counter.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef TEXT_STATISTICS_COUNTER_MACROS_SVH
`define TEXT_STATISTICS_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/tsc_pkg.sv]
// Shared constants for the text statistics counter.
// No dependencies.
package tsc_pkg;

    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int NUM_BINS           = 26;
    localparam int FIELD_BITS         = 32;
    localparam int INDEX_BITS         = 5;

    localparam logic REQ_TEXT   = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_PERIOD  = 8'h2E;
    localparam logic [7:0] CHAR_UC_A    = 8'h41;
    localparam logic [7:0] CHAR_UC_Z    = 8'h5A;
    localparam logic [7:0] CHAR_LC_A    = 8'h61;
    localparam logic [7:0] CHAR_LC_Z    = 8'h7A;

endpackage

[hdl/text_statistics_counter.sv]
// Text statistics counter: byte, word, line, sentence and letter counts.
// Depends on tsc_pkg and text_statistics_counter_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries req_type and byte_value. A
//   text transaction counts one byte; a report transaction snapshots all
//   counters, applies the non-empty fix-ups and clears the live counters.
//   Output channel (out_valid/out_ready) returns 26 transactions per report,
//   one per letter a..z, totals repeated on each, last_result set on z.
//   Order: a byte is counted in the cycle after acceptance; a report moves
//   through the input register, snapshot and emitter to the result register.
//   Throughput: one text byte per cycle, including while a report drains,
//   since the report reads from its own snapshot registers. A report gives
//   26 results at the output; a second report waits in the input register
//   until the last result of the previous one is taken, which stalls input.
//   Output stall: out_ready low holds the result register; the emitter
//   pauses, bytes keep flowing until a new report reaches the input stage.
//   Reset: all counters, histogram bins and valid flags clear; no results.
module text_statistics_counter
#(
    parameter int COUNT_BITS = tsc_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [7:0]                      byte_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tsc_pkg::FIELD_BITS-1:0]  total_count,
    output logic [tsc_pkg::FIELD_BITS-1:0]  word_count,
    output logic [tsc_pkg::FIELD_BITS-1:0]  line_count,
    output logic [tsc_pkg::FIELD_BITS-1:0]  sentence_count,
    output logic [tsc_pkg::FIELD_BITS-1:0]  letter_count,
    output logic [tsc_pkg::FIELD_BITS-1:0]  word_length_sum,
    output logic [tsc_pkg::FIELD_BITS-1:0]  sentence_length_sum,
    output logic [tsc_pkg::INDEX_BITS-1:0]  letter_index,
    output logic [tsc_pkg::FIELD_BITS-1:0]  letter_frequency,
    output logic                            last_result
);

    import tsc_pkg::*;

`include "text_statistics_counter_macros.svh"

    localparam int CW   = COUNT_BITS;
    localparam int ExtW = (CW > FIELD_BITS) ? CW : FIELD_BITS;
    localparam logic [INDEX_BITS-1:0] LastIdx = INDEX_BITS'(NUM_BINS - 1);

    typedef logic [CW-1:0]         count_t;
    typedef logic [FIELD_BITS-1:0] field_t;

    function automatic field_t to_field(input count_t v);
        logic [ExtW-1:0] e;
        e = ExtW'(v);
        return e[FIELD_BITS-1:0];
    endfunction

    // input register
    logic       s1_valid_reg;
    logic       s1_req_reg;
    logic [7:0] s1_byte_reg;

    // live counters
    count_t byte_total_reg,   byte_total_next;
    count_t line_total_reg,   line_total_next;
    count_t word_total_reg,   word_total_next;
    count_t period_total_reg, period_total_next;
    count_t alpha_total_reg,  alpha_total_next;
    count_t word_len_reg,     word_len_next;
    count_t sent_len_reg,     sent_len_next;
    count_t word_run_reg,     word_run_next;
    count_t sent_run_reg,     sent_run_next;
    count_t bins_reg [NUM_BINS];

    // report snapshot
    logic   emit_active_reg;
    logic [INDEX_BITS-1:0] emit_idx_reg;
    field_t snap_total_reg, snap_words_reg, snap_lines_reg, snap_dots_reg;
    field_t snap_alpha_reg, snap_wsum_reg, snap_ssum_reg;
    field_t snap_bins_reg [NUM_BINS];

    // output register
    logic   out_valid_reg;
    logic [INDEX_BITS-1:0] out_idx_reg;
    field_t out_freq_reg;
    logic   out_last_reg;

    logic   report_ok, s1_adv, s1_text, s1_report, out_load;
    logic   is_ws, is_upper, is_lower, is_letter;
    logic [7:0] letter_off;
    logic [INDEX_BITS-1:0] bin_idx;
    logic   nonempty;
    count_t fix_words, fix_lines, fix_dots, fix_wsum, fix_ssum;

    assign report_ok = !emit_active_reg && (!out_valid_reg || out_ready);
    assign s1_adv    = s1_valid_reg && ((s1_req_reg == REQ_TEXT) || report_ok);
    assign s1_text   = s1_adv && (s1_req_reg == REQ_TEXT);
    assign s1_report = s1_adv && (s1_req_reg == REQ_REPORT);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign out_load  = emit_active_reg && (!out_valid_reg || out_ready);

    assign is_ws      = ((s1_byte_reg >= CHAR_TAB) && (s1_byte_reg <= CHAR_CR))
                        || (s1_byte_reg == CHAR_SPACE);
    assign is_upper   = (s1_byte_reg >= CHAR_UC_A) && (s1_byte_reg <= CHAR_UC_Z);
    assign is_lower   = (s1_byte_reg >= CHAR_LC_A) && (s1_byte_reg <= CHAR_LC_Z);
    assign is_letter  = is_upper || is_lower;
    assign letter_off = s1_byte_reg - (is_upper ? CHAR_UC_A : CHAR_LC_A);
    assign bin_idx    = letter_off[INDEX_BITS-1:0];

    always_comb
    begin
        byte_total_next   = byte_total_reg + CW'(1);
        line_total_next   = line_total_reg;
        word_total_next   = word_total_reg;
        period_total_next = period_total_reg;
        alpha_total_next  = alpha_total_reg;
        word_len_next     = word_len_reg;
        sent_len_next     = sent_len_reg;
        word_run_next     = word_run_reg + CW'(1);
        sent_run_next     = sent_run_reg + CW'(1);
        if (s1_byte_reg == CHAR_PERIOD)
        begin
            sent_len_next     = sent_len_reg + sent_run_reg + CW'(1);
            sent_run_next     = '0;
            period_total_next = period_total_reg + CW'(1);
        end
        if (s1_byte_reg == CHAR_NEWLINE)
        begin
            line_total_next = line_total_reg + CW'(1);
        end
        if (is_ws)
        begin
            word_len_next   = word_len_reg + word_run_reg + CW'(1);
            word_run_next   = '0;
            word_total_next = word_total_reg + CW'(1);
        end
        if (is_letter)
        begin
            alpha_total_next = alpha_total_reg + CW'(1);
        end
    end

    // end-of-text fix-ups for a non-empty stream
    assign nonempty  = (byte_total_reg != '0);
    assign fix_words = (nonempty && word_total_reg == '0)   ? CW'(1) : word_total_reg;
    assign fix_lines = (nonempty && line_total_reg == '0)   ? CW'(1) : line_total_reg;
    assign fix_dots  = (nonempty && period_total_reg == '0) ? CW'(1) : period_total_reg;
    assign fix_wsum  = (nonempty && word_len_reg == '0) ? byte_total_reg : word_len_reg;
    assign fix_ssum  = (nonempty && sent_len_reg == '0) ? byte_total_reg : sent_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_req_reg  <= req_type;
            s1_byte_reg <= byte_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_total_reg   <= '0;
            line_total_reg   <= '0;
            word_total_reg   <= '0;
            period_total_reg <= '0;
            alpha_total_reg  <= '0;
            word_len_reg     <= '0;
            sent_len_reg     <= '0;
            word_run_reg     <= '0;
            sent_run_reg     <= '0;
            for (int k = 0; k < NUM_BINS; k++)
            begin
                bins_reg[k] <= '0;
            end
        end
        else if (s1_report)
        begin
            byte_total_reg   <= '0;
            line_total_reg   <= '0;
            word_total_reg   <= '0;
            period_total_reg <= '0;
            alpha_total_reg  <= '0;
            word_len_reg     <= '0;
            sent_len_reg     <= '0;
            word_run_reg     <= '0;
            sent_run_reg     <= '0;
            for (int k = 0; k < NUM_BINS; k++)
            begin
                bins_reg[k] <= '0;
            end
        end
        else if (s1_text)
        begin
            byte_total_reg   <= byte_total_next;
            line_total_reg   <= line_total_next;
            word_total_reg   <= word_total_next;
            period_total_reg <= period_total_next;
            alpha_total_reg  <= alpha_total_next;
            word_len_reg     <= word_len_next;
            sent_len_reg     <= sent_len_next;
            word_run_reg     <= word_run_next;
            sent_run_reg     <= sent_run_next;
            for (int k = 0; k < NUM_BINS; k++)
            begin
                if (is_letter && bin_idx == INDEX_BITS'(k))
                begin
                    bins_reg[k] <= bins_reg[k] + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_report)
        begin
            snap_total_reg <= to_field(byte_total_reg);
            snap_words_reg <= to_field(fix_words);
            snap_lines_reg <= to_field(fix_lines);
            snap_dots_reg  <= to_field(fix_dots);
            snap_alpha_reg <= to_field(alpha_total_reg);
            snap_wsum_reg  <= to_field(fix_wsum);
            snap_ssum_reg  <= to_field(fix_ssum);
            for (int k = 0; k < NUM_BINS; k++)
            begin
                snap_bins_reg[k] <= to_field(bins_reg[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_active_reg <= 1'b0;
            emit_idx_reg    <= '0;
        end
        else if (s1_report)
        begin
            emit_active_reg <= 1'b1;
            emit_idx_reg    <= '0;
        end
        else if (out_load)
        begin
            if (emit_idx_reg == LastIdx)
            begin
                emit_active_reg <= 1'b0;
                emit_idx_reg    <= '0;
            end
            else
            begin
                emit_idx_reg <= emit_idx_reg + INDEX_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_idx_reg  <= emit_idx_reg;
            out_freq_reg <= snap_bins_reg[emit_idx_reg];
            out_last_reg <= (emit_idx_reg == LastIdx);
        end
    end

    assign out_valid           = out_valid_reg;
    assign total_count         = snap_total_reg;
    assign word_count          = snap_words_reg;
    assign line_count          = snap_lines_reg;
    assign sentence_count      = snap_dots_reg;
    assign letter_count        = snap_alpha_reg;
    assign word_length_sum     = snap_wsum_reg;
    assign sentence_length_sum = snap_ssum_reg;
    assign letter_index        = out_idx_reg;
    assign letter_frequency    = out_freq_reg;
    assign last_result         = out_last_reg;

    `TSC_ASSERT_IMP(a_text_never_stalls, s1_valid_reg && s1_req_reg == REQ_TEXT, s1_adv,
        "text byte stalled in input register")
    `TSC_ASSERT_IMP(a_no_report_overlap, emit_active_reg, !s1_report,
        "report snapshot taken while a report drains")
    `TSC_ASSERT_IMP(a_last_on_final_bin, out_valid, last_result == (letter_index == LastIdx),
        "last_result does not match final bin")
    `TSC_ASSERT_NEXT(a_report_clears, s1_report,
        byte_total_reg == '0 && word_run_reg == '0 && sent_run_reg == '0,
        "counters not cleared by report")
    `TSC_ASSERT_IMP(a_index_range, out_valid, letter_index <= LastIdx,
        "letter index out of range")

endmodule
